// File: hdl/mcft_pkg.sv
package mcft_pkg;

  // Request kinds carried in req_type.
  localparam logic REQ_START    = 1'b0;
  localparam logic REQ_EXCHANGE = 1'b1;

  // Card geometry.
  localparam int FRAME_COUNT = 1024;
  localparam int SLOT_COUNT  = 4;

  // Transaction lengths in exchanged bytes.
  localparam logic [7:0] READ_LEN  = 8'd140;
  localparam logic [7:0] WRITE_LEN = 8'd138;

  // Command and reply byte values.
  localparam logic [7:0] ADDR_BASE = 8'h81;
  localparam logic [7:0] CMD_READ  = 8'h52;
  localparam logic [7:0] CMD_WRITE = 8'h57;
  localparam logic [7:0] ID_FIRST  = 8'h5A;
  localparam logic [7:0] ID_SECOND = 8'h5D;
  localparam logic [7:0] ACK_FIRST = 8'h5C;
  localparam logic [7:0] ACK_SECOND = 8'h5D;
  localparam logic [7:0] END_GOOD  = 8'h47;
  localparam logic [7:0] END_BAD_BLOCK = 8'hFF;

  // Byte positions within a read transaction.
  localparam logic [7:0] POS_ID_FIRST   = 8'd2;
  localparam logic [7:0] POS_ID_SECOND  = 8'd3;
  localparam logic [7:0] POS_FRAME_HI   = 8'd4;
  localparam logic [7:0] POS_FRAME_LO   = 8'd5;
  localparam logic [7:0] POS_RD_ACK1    = 8'd6;
  localparam logic [7:0] POS_RD_ACK2    = 8'd7;
  localparam logic [7:0] POS_RD_ECHO_HI = 8'd8;
  localparam logic [7:0] POS_RD_ECHO_LO = 8'd9;
  localparam logic [7:0] POS_RD_DATA_LO = 8'd10;
  localparam logic [7:0] POS_RD_DATA_HI = 8'd137;
  localparam logic [7:0] POS_RD_CSUM    = 8'd138;

  // Byte positions within a write transaction.
  localparam logic [7:0] POS_WR_DATA_LO = 8'd6;
  localparam logic [7:0] POS_WR_DATA_HI = 8'd133;
  localparam logic [7:0] POS_WR_CSUM    = 8'd134;
  localparam logic [7:0] POS_WR_ACK1    = 8'd135;
  localparam logic [7:0] POS_WR_ACK2    = 8'd136;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_READ  = 2'd1,
    PH_WRITE = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_SUCCESS       = 3'd0,
    ST_INVALID_BLOCK = 3'd1,
    ST_NOT_PRESENT   = 3'd2,
    ST_READ_ERR      = 3'd3,
    ST_WRITE_ERR     = 3'd4,
    ST_ADDR_MISMATCH = 3'd5,
    ST_CHECKSUM_ERR  = 3'd6
  } status_t;

  typedef struct packed {
    logic       req_type;
    logic       is_write;
    logic [2:0] slot;
    logic [9:0] frame_index;
    logic [7:0] write_data;
    logic [7:0] rx_byte;
    logic       rx_ok;
  } mcft_in_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       done_res;
    logic [2:0] status;
  } mcft_out_t;

endpackage

// File: hdl/memory_card_frame_transfer_core.sv
// Channel   Direction  Ports                          Moves
// input     in         in_valid in_ready in_data      start or byte exchange item
// result    out        out_valid out_ready out_data   next tx byte, read data, status
//
// Every accepted item yields exactly one result item, in the next cycle.
// A new item is taken every cycle unless a result is stalled; the rate is set by the single result register.
// When the result register holds an item that is not taken, in_ready drops.
// rst_n is synchronous and active low; in_ready stays low during reset.
module memory_card_frame_transfer_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mcft_pkg::mcft_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mcft_pkg::mcft_out_t out_data
);
  import mcft_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic [2:0] slot_r, slot_nxt;
  logic [9:0] frame_r, frame_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic       absent_r, absent_nxt;
  logic       link_err_r, link_err_nxt;
  logic       mismatch_r, mismatch_nxt;

  logic       out_valid_r, out_valid_nxt;
  mcft_out_t  out_data_r, out_data_nxt;

  logic       in_acc;
  mcft_out_t  res;
  logic [7:0] pos_inc;
  logic [7:0] frame_hi;
  logic [7:0] frame_lo;
  logic       range_bad;

  // Header bytes (slot address, command, frame number); payload and checksum positions are handled by the caller.
  function automatic logic [7:0] header_byte(input logic [7:0] pos, input logic wr,
                                             input logic [2:0] slot,
                                             input logic [9:0] frame);
    logic [7:0] b;
    b = 8'h00;
    if (pos == 8'd0) begin
      b = ADDR_BASE + {5'b0, slot};
    end else if (pos == 8'd1) begin
      b = wr ? CMD_WRITE : CMD_READ;
    end else if (pos == POS_FRAME_HI) begin
      b = {6'b0, frame[9:8]};
    end else if (pos == POS_FRAME_LO) begin
      b = frame[7:0];
    end
    return b;
  endfunction

  assign in_ready = rst_n && (!out_valid_r || out_ready);
  assign in_acc   = in_valid && in_ready;
  assign pos_inc  = pos_r + 8'd1;
  assign frame_hi = {6'b0, frame_r[9:8]};
  assign frame_lo = frame_r[7:0];
  assign range_bad = (int'(in_data.slot) >= SLOT_COUNT) ||
                     (int'(in_data.frame_index) >= FRAME_COUNT);

  // Per-item sequencing: next state and the result for this item.
  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    slot_nxt     = slot_r;
    frame_nxt    = frame_r;
    xor_nxt      = xor_r;
    absent_nxt   = absent_r;
    link_err_nxt = link_err_r;
    mismatch_nxt = mismatch_r;
    res          = '0;

    if (in_acc) begin
      if (in_data.req_type == REQ_START) begin
        if (range_bad) begin
          phase_nxt    = PH_IDLE;
          res.done_res = 1'b1;
          res.status   = ST_INVALID_BLOCK;
        end else begin
          phase_nxt    = in_data.is_write ? PH_WRITE : PH_READ;
          slot_nxt     = in_data.slot;
          frame_nxt    = in_data.frame_index;
          pos_nxt      = 8'd0;
          xor_nxt      = {6'b0, in_data.frame_index[9:8]} ^ in_data.frame_index[7:0];
          absent_nxt   = 1'b0;
          link_err_nxt = 1'b0;
          mismatch_nxt = 1'b0;
          res.tx_valid = 1'b1;
          res.tx_byte  = ADDR_BASE + {5'b0, in_data.slot};
        end
      end else if (phase_r != PH_IDLE) begin
        // Checks common to both directions: link timeout and card ID.
        link_err_nxt = link_err_r || !in_data.rx_ok;
        absent_nxt   = absent_r ||
                       (pos_r == POS_ID_FIRST && in_data.rx_byte != ID_FIRST) ||
                       (pos_r == POS_ID_SECOND && in_data.rx_byte != ID_SECOND);

        if (phase_r == PH_READ) begin
          if ((pos_r == POS_RD_ACK1 && in_data.rx_byte != ACK_FIRST) ||
              (pos_r == POS_RD_ACK2 && in_data.rx_byte != ACK_SECOND)) begin
            link_err_nxt = 1'b1;
          end
          if ((pos_r == POS_RD_ECHO_HI && in_data.rx_byte != frame_hi) ||
              (pos_r == POS_RD_ECHO_LO && in_data.rx_byte != frame_lo)) begin
            mismatch_nxt = 1'b1;
          end
          if (pos_r >= POS_RD_DATA_LO && pos_r <= POS_RD_DATA_HI) begin
            res.data_valid = 1'b1;
            res.data_byte  = in_data.rx_byte;
          end
          if (pos_r >= POS_RD_DATA_LO && pos_r <= POS_RD_CSUM) begin
            xor_nxt = xor_r ^ in_data.rx_byte;
          end
          if (pos_inc >= READ_LEN) begin
            res.done_res = 1'b1;
            phase_nxt    = PH_IDLE;
            priority if (absent_nxt) begin
              res.status = ST_NOT_PRESENT;
            end else if (link_err_nxt || in_data.rx_byte != END_GOOD) begin
              res.status = ST_READ_ERR;
            end else if (mismatch_nxt) begin
              res.status = ST_ADDR_MISMATCH;
            end else if (xor_nxt != 8'h00) begin
              res.status = ST_CHECKSUM_ERR;
            end else begin
              res.status = ST_SUCCESS;
            end
          end else begin
            res.tx_valid = 1'b1;
            res.tx_byte  = header_byte(pos_inc, 1'b0, slot_r, frame_r);
          end
        end else begin
          if ((pos_r == POS_WR_ACK1 && in_data.rx_byte != ACK_FIRST) ||
              (pos_r == POS_WR_ACK2 && in_data.rx_byte != ACK_SECOND)) begin
            link_err_nxt = 1'b1;
          end
          if (pos_inc >= WRITE_LEN) begin
            res.done_res = 1'b1;
            phase_nxt    = PH_IDLE;
            priority if (absent_nxt) begin
              res.status = ST_NOT_PRESENT;
            end else if (link_err_nxt) begin
              res.status = ST_WRITE_ERR;
            end else if (in_data.rx_byte == END_GOOD) begin
              res.status = ST_SUCCESS;
            end else if (in_data.rx_byte == END_BAD_BLOCK) begin
              res.status = ST_INVALID_BLOCK;
            end else begin
              res.status = ST_WRITE_ERR;
            end
          end else begin
            res.tx_valid = 1'b1;
            priority if (pos_inc >= POS_WR_DATA_LO && pos_inc <= POS_WR_DATA_HI) begin
              res.tx_byte = in_data.write_data;
              xor_nxt     = xor_r ^ in_data.write_data;
            end else if (pos_inc == POS_WR_CSUM) begin
              res.tx_byte = xor_r;
            end else begin
              res.tx_byte = header_byte(pos_inc, 1'b1, slot_r, frame_r);
            end
          end
        end
        pos_nxt = pos_inc;
      end
    end
  end

  // Result register: loads on every accepted item, clears when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state with synchronous reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      pos_r       <= 8'd0;
      slot_r      <= 3'd0;
      frame_r     <= 10'd0;
      xor_r       <= 8'd0;
      absent_r    <= 1'b0;
      link_err_r  <= 1'b0;
      mismatch_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      slot_r      <= slot_nxt;
      frame_r     <= frame_nxt;
      xor_r       <= xor_nxt;
      absent_r    <= absent_nxt;
      link_err_r  <= link_err_nxt;
      mismatch_r  <= mismatch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hdl/mcft_checker.sv
module mcft_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input mcft_pkg::mcft_out_t out_data
);
  import mcft_pkg::*;

  // A result that is not taken holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // Every accepted item shows a result in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  // The input side only stalls behind a waiting result.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with result register free");

  // Read data bytes always come mid-transaction with a next byte to send.
  a_data_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.data_valid |-> out_data.tx_valid && !out_data.done_res)
    else $error("read data byte on a final or silent result");

  // Status is zero on every result that is not final.
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.done_res |-> out_data.status == ST_SUCCESS)
    else $error("status set on a non-final result");

endmodule

bind memory_card_frame_transfer_core mcft_checker u_mcft_checker (.*);
